@@ rtl/assert_macros.svh @@
// Assertion macros shared by the interpolation block.
// Sampled on clk_i and disabled while rst_ni is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define PLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Implication check: antecedent, consequent.
`define PLI_ASSERT_IMPL(lbl, ante, cons, msg) \
  `PLI_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/pli_pkg.sv @@
// Types and codes of the piecewise-linear table interpolation block.
// No dependencies; used by the front end, queue, back end and top level through scoped names.
package pli_pkg;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int unsigned CfgW = 9;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_EMPTY,
    OP_SINGLE,
    OP_SEARCH
  } kind_e;

  typedef struct packed {
    logic               action;
    logic [7:0]         entry_index;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic signed [31:0] query_x;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    logic               no_entries;
  } out_beat_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         index;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } entry_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } bp_t;

endpackage

@@ rtl/pli_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pli_front.sv @@
// Front end: accepts input beats, drops loads outside the table, classifies queries.
// Depends on pli_pkg.
module pli_front #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pli_pkg::in_beat_t                in_beat_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] n_i,
  input  logic                             full_i,
  output logic                             push_o,
  output pli_pkg::entry_t                  push_entry_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic is_load;
  logic slot_ok;

  assign is_load    = (in_beat_i.action == pli_pkg::ACT_LOAD);
  assign slot_ok    = (32'(in_beat_i.entry_index) < 32'(TABLE_DEPTH));
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && (!is_load || slot_ok);

  always_comb begin
    push_entry_o.index = in_beat_i.entry_index;
    push_entry_o.y     = in_beat_i.entry_y;
    if (is_load) begin
      push_entry_o.kind = pli_pkg::OP_LOAD;
      push_entry_o.x    = in_beat_i.entry_x;
    end else begin
      push_entry_o.x = in_beat_i.query_x;
      if (n_i == '0) begin
        push_entry_o.kind = pli_pkg::OP_EMPTY;
      end else if (n_i == CW'(1)) begin
        push_entry_o.kind = pli_pkg::OP_SINGLE;
      end else begin
        push_entry_o.kind = pli_pkg::OP_SEARCH;
      end
    end
  end

endmodule

@@ rtl/pli_queue.sv @@
// Two-entry queue of classified items between front end and back end.
// Depends on pli_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pli_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pli_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output pli_pkg::entry_t head_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  pli_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `PLI_ASSERT_IMPL(a_no_overflow, push_i, !full_o, "push into full queue")
  `PLI_ASSERT_IMPL(a_no_underflow, pop_i, head_valid_o, "pop from empty queue")

endmodule

@@ rtl/pli_back.sv @@
// Back end: table RAM, binary search, multiply and radix-4 restoring divide.
// Depends on pli_pkg, pli_ram and assert_macros.svh.
`include "assert_macros.svh"

module pli_back #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  pli_pkg::entry_t                head_i,
  output logic                           pop_o,
  input  logic [$clog2(TABLE_DEPTH)-1:0] last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pli_pkg::out_beat_t             out_beat_o
);

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned BpW    = $bits(pli_pkg::bp_t);
  localparam int unsigned DivCnW = $clog2(64 / 2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_PROBE = 4'd3;
  localparam logic [3:0] S_CLAMP = 4'd4;
  localparam logic [3:0] S_LO    = 4'd5;
  localparam logic [3:0] S_HI    = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_ADD   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  function automatic logic [AW-1:0] mid_of(input logic [AW-1:0] l, input logic [AW-1:0] h);
    logic [AW-1:0] s;
    s = h - l;
    return l + (s >> 1);
  endfunction

  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = 33'd0 - v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // One restoring step: {quotient bit, new remainder}.
  function automatic logic [32:0] div_step(input logic [31:0] r, input logic b,
                                           input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    return (t >= {1'b0, d}) ? {1'b1, s[31:0]} : {1'b0, t[31:0]};
  endfunction

  logic [3:0]          state_q, state_d;
  logic [DivCnW-1:0]   cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  pli_pkg::out_beat_t  out_q, out_d;
  pli_pkg::out_beat_t  res_q, res_d;
  logic signed [31:0]  q_q, q_d;
  logic                single_q, single_d;
  logic [AW-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [31:0]  xl_q, xl_d, yl_q, yl_d;
  logic [31:0]         a_q, a_d, b_q, b_d, d_q, d_d;
  logic                neg_q, neg_d;
  logic [63:0]         dvd_q, dvd_d;
  logic [31:0]         rem_q, rem_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [BpW-1:0]      ram_rdata;
  pli_pkg::bp_t        wr_bp, rd;

  logic                le;
  logic [AW-1:0]       nlo, nhi;
  logic                brk;
  logic [32:0]         dx, dq, dy;
  logic [63:0]         prod;
  logic [32:0]         st1, st2;
  logic [33:0]         m;
  logic [34:0]         sum;
  logic [31:0]         sat;
  logic                out_free;

  assign wr_bp.x = head_i.x;
  assign wr_bp.y = head_i.y;
  assign rd      = pli_pkg::bp_t'(ram_rdata);

  pli_ram #(
    .Width(BpW),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(head_i.index)),
    .wdata_i(wr_bp),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign le  = (q_q <= rd.x);
  assign nlo = le ? lo_q : mid_q;
  assign nhi = le ? mid_q : hi_q;
  assign brk = ((nhi - nlo) == AW'(1)) || (nlo == last_i) || (nhi == '0);

  assign dx   = {rd.x[31], rd.x} - {xl_q[31], xl_q};
  assign dq   = {q_q[31], q_q} - {xl_q[31], xl_q};
  assign dy   = {rd.y[31], rd.y} - {yl_q[31], yl_q};
  assign prod = 64'(a_q) * 64'(b_q);

  assign st1 = div_step(rem_q, dvd_q[63], d_q);
  assign st2 = div_step(st1[31:0], dvd_q[62], d_q);

  assign m   = (|dvd_q[63:33]) ? 34'h2_0000_0000 : {1'b0, dvd_q[32:0]};
  assign sum = neg_q ? ({{3{yl_q[31]}}, yl_q} - {1'b0, m})
                     : ({{3{yl_q[31]}}, yl_q} + {1'b0, m});
  assign sat = (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) ? sum[31:0]
             : (sum[34] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    res_d       = res_q;
    q_d         = q_q;
    single_d    = single_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    xl_d        = xl_q;
    yl_d        = yl_q;
    a_d         = a_q;
    b_d         = b_q;
    d_d         = d_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          unique case (head_i.kind) inside
            pli_pkg::OP_LOAD: begin
              ram_we = 1'b1;
            end
            pli_pkg::OP_EMPTY: begin
              res_d.interp_value = '0;
              res_d.no_entries   = 1'b1;
              state_d            = S_FIN;
            end
            pli_pkg::OP_SINGLE, pli_pkg::OP_SEARCH: begin
              ram_re   = 1'b1;
              q_d      = head_i.x;
              single_d = (head_i.kind == pli_pkg::OP_SINGLE);
              state_d  = S_FIRST;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_FIRST: begin
        if (single_q || (q_q < rd.x)) begin
          res_d.interp_value = rd.y;
          res_d.no_entries   = 1'b0;
          state_d            = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = last_i;
          state_d   = S_LAST;
        end
      end
      S_LAST: begin
        if (q_q > rd.x) begin
          res_d.interp_value = rd.y;
          res_d.no_entries   = 1'b0;
          state_d            = S_FIN;
        end else begin
          lo_d      = '0;
          hi_d      = last_i;
          mid_d     = mid_of('0, last_i);
          ram_re    = 1'b1;
          ram_raddr = mid_d;
          state_d   = S_PROBE;
        end
      end
      S_PROBE: begin
        lo_d   = nlo;
        hi_d   = nhi;
        ram_re = 1'b1;
        if (!brk) begin
          mid_d     = mid_of(nlo, nhi);
          ram_raddr = mid_d;
        end else if (nhi == '0) begin
          ram_raddr = '0;
          state_d   = S_CLAMP;
        end else if (nlo == last_i) begin
          ram_raddr = last_i;
          state_d   = S_CLAMP;
        end else begin
          ram_raddr = nlo;
          state_d   = S_LO;
        end
      end
      S_CLAMP: begin
        res_d.interp_value = rd.y;
        res_d.no_entries   = 1'b0;
        state_d            = S_FIN;
      end
      S_LO: begin
        xl_d      = rd.x;
        yl_d      = rd.y;
        ram_re    = 1'b1;
        ram_raddr = hi_q;
        state_d   = S_HI;
      end
      S_HI: begin
        if (dx == '0) begin
          res_d.interp_value = yl_q;
          res_d.no_entries   = 1'b0;
          state_d            = S_FIN;
        end else begin
          a_d     = mag33(dq);
          b_d     = mag33(dy);
          d_d     = mag33(dx);
          neg_d   = dq[32] ^ dy[32] ^ dx[32];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        dvd_d   = prod;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = st2[31:0];
        dvd_d = {dvd_q[61:0], st1[32], st2[32]};
        cnt_d = cnt_q + DivCnW'(1);
        if (cnt_q == '1) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        res_d.interp_value = sat;
        res_d.no_entries   = 1'b0;
        state_d            = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    res_q    <= res_d;
    q_q      <= q_d;
    single_q <= single_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    xl_q     <= xl_d;
    yl_q     <= yl_d;
    a_q      <= a_d;
    b_q      <= b_d;
    d_q      <= d_d;
    neg_q    <= neg_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `PLI_ASSERT_IMPL(a_div_nonzero, state_q == S_DIV, d_q != '0, "divide by zero span")
  `PLI_ASSERT_IMPL(a_search_order, state_q == S_PROBE, lo_q < hi_q, "search bounds crossed")

endmodule

@@ rtl/piecewise_linear_table_interp.sv @@
// Channel | Dir | Handshake               | Beat
// in      | in  | in_valid_i / in_ready_o | pli_pkg::in_beat_t (load or query)
// out     | out | out_valid_o/out_ready_i | pli_pkg::out_beat_t (one per query)
// cfg     | in  | cfg_we_i                | cfg_wdata_i = entries_in_use
// A load is written to the table as it is popped. An interpolated query binary-searches the
// table (at most ceil(log2(entries - 1)) probes, one with two entries) through one RAM read
// port that serializes every probe, then multiplies and divides (radix-4 divider dominates).
// Empty query, clamp below first or above last entry or in the search, zero span: no mul/div.
// Reset clears the queue, the FSM and entries_in_use; the table is not cleared.
// A two-entry queue decouples intake from execution; an output register holds a stalled beat.
// Top level of the piecewise-linear table interpolation block.
// Depends on pli_pkg, pli_front, pli_queue, pli_back and assert_macros.svh.
`include "assert_macros.svh"

module piecewise_linear_table_interp #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  pli_pkg::in_beat_t        in_beat_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output pli_pkg::out_beat_t       out_beat_o,
  input  logic                     cfg_we_i,
  input  logic [pli_pkg::CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [pli_pkg::CfgW-1:0] cfg_q;
  logic [CW-1:0]            n_sat;
  logic [CW-1:0]            n_less;
  logic [AW-1:0]            last;

  logic                     full;
  logic                     push;
  pli_pkg::entry_t          push_entry;
  logic                     pop;
  logic                     head_valid;
  pli_pkg::entry_t          head;
  logic                     empty_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign n_sat  = (32'(cfg_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cfg_q);
  assign n_less = n_sat - CW'(1);
  assign last   = n_less[AW-1:0];

  pli_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .n_i         (n_sat),
    .full_i      (full),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  pli_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  pli_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .last_i      (last),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  assign empty_beat = out_valid_o && out_beat_o.no_entries;

  `PLI_ASSERT_IMPL(a_empty_zero, empty_beat, out_beat_o.interp_value == '0, "empty beat value")

endmodule
